>>> rtl/ivkr_pkg.sv
// Package for impossible_value_key_recovery: constants, types and helpers
// for the histogram store and the recovery sequencer. No dependencies.
package ivkr_pkg;

   localparam int SBOX_COUNT  = 8;
   localparam int COUNT_WIDTH = 32;
   localparam int BIN_COUNT   = 16;
   localparam int VALUE_W     = 4;
   localparam int SBOX_AW     = (SBOX_COUNT > 1) ? $clog2(SBOX_COUNT) : 1;
   localparam int BIN_DEPTH   = SBOX_COUNT * BIN_COUNT;
   localparam int BIN_AW      = SBOX_AW + VALUE_W;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 80;

   localparam logic [VALUE_W-1:0] NIBBLE_MASK = 4'hF;

   localparam logic KIND_ADD     = 1'b0;
   localparam logic KIND_RECOVER = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN
   } state_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [BIN_AW-1:0]  bin_addr;
      logic [SBOX_AW-1:0] samp_addr;
      logic               wr_en;
      count_type          bin_wdata;
      count_type          samp_wdata;
   } store_req_type;

   typedef struct packed {
      count_type bin_data;
      count_type samp_data;
   } store_rsp_type;

   // first field in the highest bits, last field in the lowest bits
   typedef struct packed {
      logic [31:0]        target_samples;
      logic [VALUE_W-1:0] sample_value;
      logic [3:0]         solved_sboxes;
      logic [31:0]        rec_key;
      logic               status;
   } rsp_type;

   // bit sbox of each byte, most significant byte gives bit 0
   function automatic logic [VALUE_W-1:0] gather_bits(input logic [31:0] word,
                                                      input logic [2:0] sbox);
      logic [VALUE_W-1:0] v;
      for (int row = 0; row < 4; row++) begin
         v[row] = word[(3 - row) * 8 + int'(sbox)];
      end
      return v;
   endfunction

   function automatic count_type sat_inc(input count_type c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic logic [31:0] limit_out(input count_type c);
      logic [63:0] w;
      w = 64'(c);
      return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

endpackage

>>> rtl/impossible_value_key_recovery.sv
// Add beat: one read and one write-back of the bin and sample RAMs; the result is
// registered after the write-back, and the next beat is accepted back in idle once the result is free or taken.
// Recover beat: a scan over all SBOX_COUNT*16 bins (128), one bin RAM read per cycle.
// Synchronous active-high reset clears the store through per-entry valid bits;
// no clearing pass. The delta register resets to zero.
module impossible_value_key_recovery
   import ivkr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // sbox_sel[2:0], cipher_word[34:3]
   input  logic                   req_tuser,  // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[0], rec_key[32:1], solved_sboxes[36:33], sample_value[40:37],
   // target_samples[72:41]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [3:0]             csr_wr_data
);

   store_req_type store_req;
   store_rsp_type store_rsp;
   rsp_type       rsp_data;

   ivkr_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .store_rsp (store_rsp)
   );

   ivkr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_kind    (req_tuser),
      .req_target  (req_tdata[2:0]),
      .req_word    (req_tdata[34:3]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .store_req   (store_req),
      .store_rsp   (store_rsp),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_data    (rsp_data)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_data);

endmodule

>>> rtl/ivkr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ivkr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ivkr_store.sv
// Histogram store: bin counter RAM, per-S-box sample RAM and valid bits
// that make unwritten entries read as zero. Depends on ivkr_pkg, ivkr_ram.
module ivkr_store
   import ivkr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  store_req_type store_req,
   output store_rsp_type store_rsp
);

   logic [BIN_DEPTH-1:0]  bin_vld_ff;
   logic [SBOX_COUNT-1:0] samp_vld_ff;
   logic                  bin_rd_vld_ff;
   logic                  samp_rd_vld_ff;
   count_type             bin_q;
   count_type             samp_q;

   ivkr_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_DEPTH)) u_bin_ram (
      .clock   (clock),
      .wr_en   (store_req.wr_en),
      .wr_addr (store_req.bin_addr),
      .wr_data (store_req.bin_wdata),
      .rd_addr (store_req.bin_addr),
      .rd_data (bin_q)
   );

   ivkr_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(SBOX_COUNT)) u_samp_ram (
      .clock   (clock),
      .wr_en   (store_req.wr_en),
      .wr_addr (store_req.samp_addr),
      .wr_data (store_req.samp_wdata),
      .rd_addr (store_req.samp_addr),
      .rd_data (samp_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_vld_ff     <= '0;
         samp_vld_ff    <= '0;
         bin_rd_vld_ff  <= 1'b0;
         samp_rd_vld_ff <= 1'b0;
      end else begin
         bin_rd_vld_ff  <= bin_vld_ff[store_req.bin_addr];
         samp_rd_vld_ff <= samp_vld_ff[store_req.samp_addr];
         if (store_req.wr_en) begin
            bin_vld_ff[store_req.bin_addr]   <= 1'b1;
            samp_vld_ff[store_req.samp_addr] <= 1'b1;
         end
      end
   end

   assign store_rsp.bin_data  = bin_rd_vld_ff  ? bin_q  : '0;
   assign store_rsp.samp_data = samp_rd_vld_ff ? samp_q : '0;

endmodule

>>> rtl/ivkr_ctrl.sv
// Sequencer: add read-modify-write, recover scan over all bins, delta
// register and result register. Depends on ivkr_pkg.
module ivkr_ctrl
   import ivkr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_kind,
   input  logic [2:0]    req_target,
   input  logic [31:0]   req_word,
   input  logic          csr_wr_en,
   input  logic [3:0]    csr_wr_data,
   output store_req_type store_req,
   input  store_rsp_type store_rsp,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output rsp_type       rsp_data
);

   state_type state_ff, state_in;

   logic [BIN_AW-1:0]  add_addr_ff, add_addr_in;
   logic [SBOX_AW-1:0] add_sbox_ff, add_sbox_in;
   logic [VALUE_W-1:0] add_value_ff, add_value_in;
   logic               add_bad_ff, add_bad_in;
   logic [BIN_AW-1:0]  idx_ff, idx_in;
   logic [1:0]         empty_ff, empty_in;
   logic [VALUE_W-1:0] miss_ff, miss_in;
   logic               fail_ff, fail_in;
   logic [3:0]         succ_ff, succ_in;
   logic [31:0]        key_ff, key_in;
   logic [VALUE_W-1:0] delta_ff, delta_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               req_bad;
   logic [VALUE_W-1:0] req_value;
   logic [BIN_AW-1:0]  req_addr;
   logic               load_add;
   logic               load_scan;
   logic [BIN_AW-1:0]  idx_next;
   logic [SBOX_AW-1:0] scan_sbox;
   logic [VALUE_W-1:0] scan_value;
   logic               scan_last;
   logic               sbox_end;
   logic               bin_zero;
   logic [1:0]         empty_cur, empty_nx;
   logic [VALUE_W-1:0] miss_cur, miss_nx;
   logic               sbox_ok;
   logic               sbox_take;
   logic [VALUE_W-1:0] key_word;
   logic [31:0]        key_upd;
   count_type          samp_inc;
   rsp_type            add_rsp;
   rsp_type            scan_rsp;

   assign accept    = req_tvalid && req_tready;
   assign req_bad   = ({1'b0, req_target} >= 4'(SBOX_COUNT));
   assign req_value = gather_bits(req_word, req_target);
   assign req_addr  = {req_target[SBOX_AW-1:0], req_value};

   assign idx_next   = idx_ff + 1'b1;
   assign scan_sbox  = idx_ff[BIN_AW-1:VALUE_W];
   assign scan_value = idx_ff[VALUE_W-1:0];
   assign scan_last  = (idx_ff == BIN_AW'(BIN_DEPTH - 1));
   assign sbox_end   = (scan_value == VALUE_W'(BIN_COUNT - 1));
   assign samp_inc   = sat_inc(store_rsp.samp_data);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_kind == KIND_RECOVER) ? ST_SCAN : ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready           = 1'b0;
      load_add             = 1'b0;
      load_scan            = 1'b0;
      store_req.bin_addr   = add_addr_ff;
      store_req.samp_addr  = add_sbox_ff;
      store_req.wr_en      = 1'b0;
      store_req.bin_wdata  = sat_inc(store_rsp.bin_data);
      store_req.samp_wdata = samp_inc;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_kind == KIND_RECOVER) begin
               store_req.bin_addr  = '0;
               store_req.samp_addr = '0;
            end else begin
               store_req.bin_addr  = req_addr;
               store_req.samp_addr = req_target[SBOX_AW-1:0];
            end
         end
         ST_ADD: begin
            store_req.wr_en = !add_bad_ff;
            load_add        = 1'b1;
         end
         ST_SCAN: begin
            store_req.bin_addr  = idx_next;
            store_req.samp_addr = idx_next[BIN_AW-1:VALUE_W];
            load_scan           = scan_last;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // per-S-box empty-bin tracking during the scan
   always_comb begin
      bin_zero  = (store_rsp.bin_data == '0);
      empty_cur = (scan_value == '0) ? 2'd0 : empty_ff;
      miss_cur  = (scan_value == '0) ? '0 : miss_ff;
      empty_nx  = empty_cur;
      if (bin_zero && empty_cur != 2'd2) begin
         empty_nx = empty_cur + 2'd1;
      end
      miss_nx   = (bin_zero && empty_cur == 2'd0) ? scan_value : miss_cur;
      sbox_ok   = (store_rsp.samp_data != '0) && (empty_nx == 2'd1);
      sbox_take = sbox_end && !fail_ff && sbox_ok;
      key_word  = (miss_nx ^ delta_ff) & NIBBLE_MASK;
      key_upd   = key_ff;
      for (int row = 0; row < 4; row++) begin
         key_upd[{2'(3 - row), 3'(scan_sbox)}] = key_word[row];
      end
   end

   always_comb begin
      add_rsp                   = '0;
      add_rsp.status            = add_bad_ff;
      add_rsp.sample_value      = add_bad_ff ? '0 : add_value_ff;
      add_rsp.target_samples    = add_bad_ff ? '0 : limit_out(samp_inc);

      scan_rsp               = '0;
      scan_rsp.status        = fail_in;
      scan_rsp.rec_key       = fail_in ? '0 : key_in;
      scan_rsp.solved_sboxes = succ_in;
   end

   always_comb begin
      add_addr_in  = add_addr_ff;
      add_sbox_in  = add_sbox_ff;
      add_value_in = add_value_ff;
      add_bad_in   = add_bad_ff;
      idx_in       = idx_ff;
      empty_in     = empty_ff;
      miss_in      = miss_ff;
      fail_in      = fail_ff;
      succ_in      = succ_ff;
      key_in       = key_ff;
      delta_in     = csr_wr_en ? (csr_wr_data & NIBBLE_MASK) : delta_ff;
      if (accept) begin
         add_addr_in  = req_addr;
         add_sbox_in  = req_target[SBOX_AW-1:0];
         add_value_in = req_value;
         add_bad_in   = req_bad;
         idx_in       = '0;
         fail_in      = 1'b0;
         succ_in      = '0;
         key_in       = '0;
      end else if (state_ff == ST_SCAN) begin
         idx_in   = idx_next;
         empty_in = empty_nx;
         miss_in  = miss_nx;
         fail_in  = fail_ff | (sbox_end & !sbox_ok);
         succ_in  = sbox_take ? succ_ff + 4'd1 : succ_ff;
         key_in   = sbox_take ? key_upd : key_ff;
      end
      rsp_valid_in = load_add || load_scan || (rsp_valid_ff && !rsp_tready);
      priority if (load_add) begin
         rsp_data_in = add_rsp;
      end else if (load_scan) begin
         rsp_data_in = scan_rsp;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         delta_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         delta_ff     <= delta_in;
      end
   end

   always_ff @(posedge clock) begin
      add_addr_ff  <= add_addr_in;
      add_sbox_ff  <= add_sbox_in;
      add_value_ff <= add_value_in;
      add_bad_ff   <= add_bad_in;
      idx_ff       <= idx_in;
      empty_ff     <= empty_in;
      miss_ff      <= miss_in;
      fail_ff      <= fail_in;
      succ_ff      <= succ_in;
      key_ff       <= key_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> rtl/ivkr_checker.sv
// Port-level checker for impossible_value_key_recovery, bound to the top.
// Depends on ivkr_pkg.
module ivkr_checker
   import ivkr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   csr_wr_en,
   input logic [3:0]             csr_wr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous beat in flight");

   a_add_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_ADD |-> ##2 rsp_tvalid)
      else $error("add result not presented two cycles after acceptance");

   a_fail_no_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[32:1] == '0)
      else $error("failed result carries a round key");

   a_succ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[36:33] <= 4'(SBOX_COUNT))
      else $error("successful S-box count out of range");

endmodule

bind impossible_value_key_recovery ivkr_checker u_ivkr_checker (.*);
